// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/nasd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the dispatcher.
// No dependencies.
package nasd_pkg;

  localparam int POOL_SIZE = 16;
  localparam int SRV_W     = 4;
  localparam int NSRV_W    = 5;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 31;
  localparam int END_W     = 32;

  localparam logic [NSRV_W-1:0] NSRV_RESET = NSRV_W'(POOL_SIZE);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_REPORT   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming item, clear the walk registers
    logic calc_free;  // register the free vector
    logic pick;       // rotating priority pick, advance the start position
    logic update;     // write the chosen server and load a dispatch result
    logic walk_max;   // fold one server into the running maximum
    logic walk_next;  // step the walk index
    logic emit;       // load a report result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic match;      // count at the walk index equals the maximum
    logic at_last;    // walk index is the last busiest server
    logic walk_end;   // walk index is the last server in use
  } stat_t;

endpackage

// ===== hw/rtl/nasd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences dispatch and report items.
// Depends on nasd_pkg.
module nasd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_cmd,
  input  nasd_pkg::stat_t  stat_i,
  output nasd_pkg::cmd_t   cmd_o
);
  import nasd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREE  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_RMAX  = 3'd4;
  localparam logic [2:0] S_REMIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.capture = 1'b1;
          state_nxt = (in_cmd == CMD_REPORT) ? S_RMAX : S_FREE;
        end
      end
      S_FREE: begin
        cmd_o.calc_free = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.update = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RMAX: begin
        cmd_o.walk_max = 1'b1;
        if (stat_i.walk_end) begin
          state_nxt = S_REMIT;
        end
      end
      S_REMIT: begin
        if (!stat_i.match) begin
          cmd_o.walk_next = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.at_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd_o.walk_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/nasd_dp.sv =====
// Datapath of the dispatcher: server state, free check, rotating pick, report walk,
// output register. Depends on nasd_pkg.
module nasd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nasd_pkg::NSRV_W-1:0] cfg_wr_data,
  input  logic                        in_cmd,
  input  logic [nasd_pkg::TIME_W-1:0] in_arrival,
  input  logic [nasd_pkg::TIME_W-1:0] in_load,
  input  nasd_pkg::cmd_t              cmd_i,
  output nasd_pkg::stat_t             stat_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nasd_pkg::SRV_W-1:0]  out_server_id,
  output logic                        out_dropped,
  output logic [nasd_pkg::CNT_W-1:0]  out_served,
  output logic [nasd_pkg::CNT_W-1:0]  out_max,
  output logic                        out_is_report,
  output logic                        out_is_last
);
  import nasd_pkg::*;

  // Lowest set bit of a vector; valid only when the vector is not zero.
  function automatic logic [SRV_W-1:0] first_set(input logic [POOL_SIZE-1:0] v);
    logic [SRV_W-1:0] pos;
    pos = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (v[i]) pos = SRV_W'(i);
    end
    return pos;
  endfunction

  logic [NSRV_W-1:0]    num_srv_r;
  logic [END_W-1:0]     end_r [POOL_SIZE];
  logic [POOL_SIZE-1:0] assigned_r;
  logic [CNT_W-1:0]     count_r [POOL_SIZE];
  logic [CNT_W-1:0]     top_r;
  logic [SRV_W-1:0]     start_r;

  logic                 cmd_r;
  logic [TIME_W-1:0]    arrival_r;
  logic [TIME_W-1:0]    load_r;
  logic [POOL_SIZE-1:0] free_r;
  logic                 found_r;
  logic [SRV_W-1:0]     idx_r;
  logic [CNT_W-1:0]     best_r;
  logic [SRV_W-1:0]     last_r;

  logic                 out_valid_r;
  logic [SRV_W-1:0]     out_id_r;
  logic                 out_drop_r;
  logic [CNT_W-1:0]     out_served_r;
  logic [CNT_W-1:0]     out_max_r;
  logic                 out_rep_r;
  logic                 out_last_r;

  // Servers in use: zero counts as one, anything above the pool as the pool.
  logic [NSRV_W-1:0]    n_use;
  logic [SRV_W-1:0]     start_eff;
  logic [SRV_W-1:0]     start_next;
  logic [POOL_SIZE-1:0] free_now;
  logic [POOL_SIZE-1:0] free_hi;
  logic [CNT_W-1:0]     cnt_cur;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     top_new;
  logic                 out_free;

  always_comb begin
    if (num_srv_r == '0) begin
      n_use = NSRV_W'(1);
    end else if (num_srv_r > NSRV_W'(POOL_SIZE)) begin
      n_use = NSRV_W'(POOL_SIZE);
    end else begin
      n_use = num_srv_r;
    end
  end

  assign start_eff  = ({1'b0, start_r} < n_use) ? start_r : '0;
  assign start_next = ({1'b0, start_eff} + NSRV_W'(1) >= n_use) ? '0
                      : start_eff + SRV_W'(1);

  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_now[i] = (NSRV_W'(i) < n_use) &&
                    (!assigned_r[i] || end_r[i] <= {1'b0, arrival_r});
      free_hi[i]  = free_r[i] && (SRV_W'(i) >= start_eff);
    end
  end

  assign cnt_cur  = count_r[idx_r];
  assign cnt_inc  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
  assign top_new  = (cnt_inc > top_r) ? cnt_inc : top_r;
  assign out_free = !out_valid_r || out_ready;

  assign stat_o.out_free  = out_free;
  assign stat_o.match     = (cnt_cur == best_r);
  assign stat_o.at_last   = (idx_r == last_r);
  assign stat_o.walk_end  = ({1'b0, idx_r} == n_use - NSRV_W'(1));

  // Control state: configuration, occupancy, counts, start position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_srv_r  <= NSRV_RESET;
      assigned_r <= '0;
      top_r      <= '0;
      start_r    <= '0;
      for (int i = 0; i < POOL_SIZE; i++) count_r[i] <= '0;
    end else begin
      if (cfg_wr_en) num_srv_r <= cfg_wr_data;
      if (cmd_i.pick) start_r <= start_next;
      if (cmd_i.update && found_r) begin
        assigned_r[idx_r] <= 1'b1;
        count_r[idx_r]    <= cnt_inc;
        top_r             <= top_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.update && found_r) end_r[idx_r] <= {1'b0, arrival_r} + {1'b0, load_r};
  end

  // Item registers, free vector and walk registers.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r     <= in_cmd;
      arrival_r <= in_arrival;
      load_r    <= in_load;
      idx_r     <= '0;
      best_r    <= '0;
      last_r    <= '0;
    end
    if (cmd_i.calc_free) free_r <= free_now;
    if (cmd_i.pick) begin
      found_r <= |free_r;
      idx_r   <= (|free_hi) ? first_set(free_hi) : first_set(free_r);
    end
    if (cmd_i.walk_max) begin
      if (cnt_cur >= best_r) begin
        best_r <= cnt_cur;
        last_r <= idx_r;
      end
      idx_r <= stat_o.walk_end ? '0 : idx_r + SRV_W'(1);
    end
    if (cmd_i.walk_next) idx_r <= idx_r + SRV_W'(1);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.update || cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.update) begin
      out_id_r     <= found_r ? idx_r : '0;
      out_drop_r   <= !found_r;
      out_served_r <= found_r ? cnt_inc : '0;
      out_max_r    <= found_r ? top_new : top_r;
      out_rep_r    <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (cmd_i.emit) begin
      out_id_r     <= idx_r;
      out_drop_r   <= 1'b0;
      out_served_r <= cnt_cur;
      out_max_r    <= best_r;
      out_rep_r    <= 1'b1;
      out_last_r   <= stat_o.at_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_server_id = out_id_r;
  assign out_dropped   = out_drop_r;
  assign out_served    = out_served_r;
  assign out_max       = out_max_r;
  assign out_is_report = out_rep_r;
  assign out_is_last   = out_last_r;

endmodule

// ===== hw/rtl/next_available_server_dispatch.sv =====
// Top level of the next-available server dispatcher: controller plus datapath.
// Depends on nasd_pkg, nasd_ctrl and nasd_dp.
//
//   Channel  Direction  Contents
//   in_      slave      tuser = cmd, tdata = arrival_time, load_time
//   out_     master     tuser = is_report, tlast = is_last,
//                       tdata = server_id, dropped, served_count, max_count
//   cfg_     write      num_servers, taken at any edge with cfg_wr_en high
//
// After acceptance a dispatch item passes the free check, the rotating pick and
// the state update before its result enters the output register; a new item is
// taken only once the controller is back in idle.
// A report walks the servers in use through the single count read port: first to
// find the maximum, then again to emit each server that holds it.
// rst_n is synchronous and active low; it clears all counts and occupancy.
// A held output stalls the update or emit step; in_tready stays low meanwhile.
module next_available_server_dispatch (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: num_servers in bits 4:0.
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [30:0] arrival_time, [61:31] load_time, [63:62] zero
  input  logic        in_tuser,   // [0] cmd
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] server_id, [4] dropped, [20:5] served_count,
                                  // [36:21] max_count, [39:37] zero
  output logic        out_tuser,  // [0] is_report
  output logic        out_tlast   // is_last
);
  import nasd_pkg::*;

  cmd_t             dp_cmd;
  stat_t            dp_stat;
  logic [SRV_W-1:0] res_id;
  logic             res_drop;
  logic [CNT_W-1:0] res_served;
  logic [CNT_W-1:0] res_max;

  nasd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  nasd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_cmd        (in_tuser),
    .in_arrival    (in_tdata[30:0]),
    .in_load       (in_tdata[61:31]),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_server_id (res_id),
    .out_dropped   (res_drop),
    .out_served    (res_served),
    .out_max       (res_max),
    .out_is_report (out_tuser),
    .out_is_last   (out_tlast)
  );

  assign out_tdata = {3'b000, res_max, res_served, res_drop, res_id};

endmodule

// ===== hw/rtl/nasd_checker.sv =====
// Port-level checker for the dispatcher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nasd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A held result keeps its contents.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // A dispatch gives exactly one result, so it is always the last.
  `ASSERT_NEVER(a_disp_last, clk, rst_n, out_tvalid && !out_tuser && !out_tlast, "dispatch result without last")

  // A dropped request reports server zero with a zero count and is never a report.
  `ASSERT_NEVER(a_drop_fields, clk, rst_n, out_tvalid && out_tdata[4] && (out_tuser || out_tdata[3:0] != 4'd0 || out_tdata[20:5] != 16'd0), "bad fields on dropped result")

  // Every server named in a report holds the maximum count.
  `ASSERT_NEVER(a_rep_count, clk, rst_n, out_tvalid && out_tuser && out_tdata[20:5] != out_tdata[36:21], "report count differs from maximum")

  // A served server never holds more than the running maximum.
  `ASSERT_NEVER(a_disp_max, clk, rst_n, out_tvalid && !out_tuser && out_tdata[20:5] > out_tdata[36:21], "served count above maximum")

endmodule

bind next_available_server_dispatch nasd_checker u_nasd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
